FILE: design/touch_contact_id_remapper_assert.svh
// Assertion macros for the touch contact id remapper
`ifndef TOUCH_CONTACT_ID_REMAPPER_ASSERT_SVH
`define TOUCH_CONTACT_ID_REMAPPER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TCIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TCIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TCIR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/tcir_pkg.sv
// Types, codes and constants shared across the remapper
package tcir_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;
	localparam int COORD_W = 32;
	localparam int SIZE_W = 16;
	localparam int FRAC_SHIFT = 8;
	localparam int NUM_W = COORD_W + FRAC_SHIFT;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ACT_DOWN = 2'd0;
	localparam logic [1:0] ACT_UP = 2'd1;
	localparam logic [1:0] ACT_MOTION = 2'd2;
	localparam logic [1:0] ACT_CANCEL = 2'd3;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_PUSH,
		F_CANCEL
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_DIV
	} back_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] pointer_id;
		logic do_div;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic push;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic empty;
		cmd_t cmd;
	} q_rd_t;

endpackage

FILE: design/tcir_if.sv
// Event and result channel interfaces
interface tcir_evt_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic signed [31:0] contact_id;
	logic on_target_surface;
	logic signed [31:0] x_fixed;
	logic signed [31:0] y_fixed;

	modport source (output valid, action, contact_id, on_target_surface, x_fixed, y_fixed,
		input ready);
	modport sink (input valid, action, contact_id, on_target_surface, x_fixed, y_fixed,
		output ready);
endinterface

interface tcir_res_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [31:0] pointer_id;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic last;

	modport source (output valid, kind, pointer_id, pos_x, pos_y, last, input ready);
	modport sink (input valid, kind, pointer_id, pos_x, pos_y, last, output ready);
endinterface

FILE: design/tcir_front.sv
// Front end: accepts events, scans the contact table and issues commands
`include "touch_contact_id_remapper_assert.svh"

module tcir_front
	import tcir_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	tcir_evt_if.sink evt,
	input logic q_full,
	output q_wr_t q_wr
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	front_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [1:0] act_q;
	logic [31:0] cid_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic found_q, free_found_q;
	logic [IDX_W-1:0] match_q, free_q;
	logic [31:0] mptr_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0] contact_q [TABLE_DEPTH];
	logic [31:0] pointer_q [TABLE_DEPTH];
	logic [31:0] next_ptr_q;

	logic accept, scan_end, cur_valid, cur_hit, more_valid;
	logic tgt_ok, need_push, push, adv, alloc;
	logic [IDX_W-1:0] slot;
	logic [31:0] ptr_inc;
	cmd_t cmd;

	assign accept = evt.valid && evt.ready;
	assign scan_end = (idx_q == LAST_IDX);
	assign cur_valid = valid_q[idx_q];
	assign cur_hit = cur_valid && (contact_q[idx_q] == cid_q);
	assign tgt_ok = found_q || free_found_q;
	assign slot = found_q ? match_q : free_q;
	assign ptr_inc = next_ptr_q + 32'd1;

	always_comb begin
		more_valid = 1'b0;
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			if ((IDX_W'(j) > idx_q) && valid_q[j]) begin
				more_valid = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (evt.action == ACT_CANCEL) begin
						state_d = F_CANCEL;
					end else if ((evt.action == ACT_DOWN) && !evt.on_target_surface) begin
						state_d = F_IDLE;
					end else begin
						state_d = F_SCAN;
					end
				end
			end
			F_SCAN: begin
				if (scan_end) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!need_push || !q_full) begin
					state_d = F_IDLE;
				end
			end
			F_CANCEL: begin
				if (adv && scan_end) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		evt.ready = 1'b0;
		need_push = 1'b0;
		push = 1'b0;
		adv = 1'b0;
		alloc = 1'b0;
		cmd = '0;
		unique case (state_q)
			F_IDLE: begin
				evt.ready = 1'b1;
			end
			F_SCAN: begin
			end
			F_PUSH: begin
				need_push = (act_q == ACT_DOWN) || found_q;
				push = need_push && !q_full;
				cmd.last = 1'b1;
				case (act_q)
					ACT_DOWN: begin
						if (tgt_ok) begin
							cmd.kind = KIND_ADD;
							cmd.pointer_id = next_ptr_q;
							cmd.do_div = 1'b1;
							cmd.x = x_q;
							cmd.y = y_q;
							alloc = push;
						end else begin
							cmd.kind = KIND_FULL;
						end
					end
					ACT_UP: begin
						cmd.kind = KIND_REMOVE;
						cmd.pointer_id = mptr_q;
					end
					default: begin
						cmd.kind = KIND_ADD;
						cmd.pointer_id = mptr_q;
						cmd.do_div = 1'b1;
						cmd.x = x_q;
						cmd.y = y_q;
					end
				endcase
			end
			F_CANCEL: begin
				push = cur_valid && !q_full;
				adv = !cur_valid || !q_full;
				cmd.kind = KIND_REMOVE;
				cmd.pointer_id = pointer_q[idx_q];
				cmd.last = !more_valid;
			end
			default: begin
			end
		endcase
	end

	assign q_wr.push = push;
	assign q_wr.cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			valid_q <= '0;
			next_ptr_q <= 32'd1;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == F_SCAN) begin
				if (cur_hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (!cur_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (!scan_end) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if ((state_q == F_CANCEL) && adv) begin
				valid_q[idx_q] <= 1'b0;
				if (!scan_end) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (alloc) begin
				valid_q[slot] <= 1'b1;
				next_ptr_q <= (ptr_inc == 32'd0) ? 32'd1 : ptr_inc;
			end
			if (push && (state_q == F_PUSH) && (act_q == ACT_UP)) begin
				valid_q[match_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= evt.action;
			cid_q <= evt.contact_id;
			x_q <= evt.x_fixed;
			y_q <= evt.y_fixed;
		end
		if (state_q == F_SCAN) begin
			if (cur_hit && !found_q) begin
				match_q <= idx_q;
				mptr_q <= pointer_q[idx_q];
			end
			if (!cur_valid && !free_found_q) begin
				free_q <= idx_q;
			end
		end
		if (alloc) begin
			contact_q[slot] <= cid_q;
			pointer_q[slot] <= next_ptr_q;
		end
	end

	`TCIR_ASSERT_IMPLY(a_ptr_nonzero, clk, arst_n, 1'b1, next_ptr_q != 32'd0)
	`TCIR_ASSERT_IMPLY(a_add_has_id, clk, arst_n, push && (cmd.kind == KIND_ADD),
		cmd.pointer_id != 32'd0)
	`TCIR_ASSERT_IMPLY(a_ready_idle, clk, arst_n, evt.ready, state_q == F_IDLE)

endmodule

FILE: design/tcir_queue.sv
// Command queue between the front and back ends
module tcir_queue
	import tcir_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input q_wr_t q_wr,
	output logic full,
	input logic pop,
	output q_rd_t q_rd
);

	cmd_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_rd.empty = (cnt_q == '0);
	assign q_rd.cmd = mem_q[rd_q];
	assign do_push = q_wr.push && !full;
	assign do_pop = pop && !q_rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= q_wr.cmd;
		end
	end

endmodule

FILE: design/tcir_div.sv
// Restoring divider: coordinate times 256 over surface size, saturated signed Q24.8
module tcir_div
	import tcir_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [COORD_W-1:0] coord,
	input logic [SIZE_W-1:0] size,
	output logic busy,
	output logic [COORD_W-1:0] quot
);

	logic busy_q, neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SIZE_W-1:0] rem_q, dvs_q;
	logic [NUM_W-1:0] num_q;
	logic [COORD_W-1:0] mag;
	logic [SIZE_W:0] rem_sh, diff;
	logic ge, pos_over, neg_over;

	assign mag = coord[COORD_W-1] ? (~coord + 1'b1) : coord;
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge = (rem_sh >= {1'b0, dvs_q});
	assign diff = rem_sh - {1'b0, dvs_q};
	assign busy = busy_q;

	assign pos_over = |num_q[NUM_W-1:COORD_W-1];
	assign neg_over = (|num_q[NUM_W-1:COORD_W]) ||
		(num_q[COORD_W-1] && (|num_q[COORD_W-2:0]));

	always_comb begin
		if (neg_q) begin
			quot = neg_over ? {1'b1, {(COORD_W-1){1'b0}}} : (~num_q[COORD_W-1:0] + 1'b1);
		end else begin
			quot = pos_over ? {1'b0, {(COORD_W-1){1'b1}}} : num_q[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= coord[COORD_W-1];
			num_q <= {mag, {FRAC_SHIFT{1'b0}}};
			rem_q <= '0;
			dvs_q <= (size == '0) ? SIZE_W'(1) : size;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

endmodule

FILE: design/tcir_back.sv
// Back end: runs the position divides and drives the result register
`include "touch_contact_id_remapper_assert.svh"

module tcir_back
	import tcir_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input q_rd_t q_rd,
	output logic pop,
	input logic [SIZE_W-1:0] width_px,
	input logic [SIZE_W-1:0] height_px,
	tcir_res_if.source res
);

	back_state_t state_q, state_d;
	logic out_valid_q;
	logic [1:0] kind_q, hold_kind_q;
	logic [31:0] ptr_q, hold_ptr_q;
	logic [COORD_W-1:0] pos_x_q, pos_y_q;
	logic last_q, hold_last_q;

	logic out_free, div_start, ld_direct, ld_div, x_busy, y_busy;
	logic [COORD_W-1:0] x_quot, y_quot;

	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (div_start) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (ld_div) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		div_start = 1'b0;
		ld_direct = 1'b0;
		ld_div = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop = !q_rd.empty && out_free;
				div_start = pop && q_rd.cmd.do_div;
				ld_direct = pop && !q_rd.cmd.do_div;
			end
			B_DIV: begin
				ld_div = !x_busy && !y_busy && out_free;
			end
			default: begin
			end
		endcase
	end

	tcir_div u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.coord(q_rd.cmd.x),
		.size(width_px),
		.busy(x_busy),
		.quot(x_quot)
	);

	tcir_div u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.coord(q_rd.cmd.y),
		.size(height_px),
		.busy(y_busy),
		.quot(y_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_direct || ld_div) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			hold_kind_q <= q_rd.cmd.kind;
			hold_ptr_q <= q_rd.cmd.pointer_id;
			hold_last_q <= q_rd.cmd.last;
		end
		if (ld_direct) begin
			kind_q <= q_rd.cmd.kind;
			ptr_q <= q_rd.cmd.pointer_id;
			last_q <= q_rd.cmd.last;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else if (ld_div) begin
			kind_q <= hold_kind_q;
			ptr_q <= hold_ptr_q;
			last_q <= hold_last_q;
			pos_x_q <= x_quot;
			pos_y_q <= y_quot;
		end
	end

	assign res.valid = out_valid_q;
	assign res.kind = kind_q;
	assign res.pointer_id = ptr_q;
	assign res.pos_x = pos_x_q;
	assign res.pos_y = pos_y_q;
	assign res.last = last_q;

	`TCIR_ASSERT_NEXT(a_div_runs, clk, arst_n, div_start, x_busy && y_busy)
	`TCIR_ASSERT_IMPLY(a_full_shape, clk, arst_n, out_valid_q && (kind_q == KIND_FULL),
		(ptr_q == 32'd0) && last_q)
	`TCIR_ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, pop, !q_rd.empty)

endmodule

FILE: design/touch_contact_id_remapper.sv
// Top level of the touch contact id remapper with its register port
//
// Touch events enter on evt and result beats leave on res. The front end scans the
// contact table one slot per cycle, holding a cancel scan while the queue is full;
// a cancel gives one remove beat per stored contact. Commands then pass a four-entry
// queue to the back end, where every add or motion runs two 40-step restoring
// dividers side by side; the back end takes no new command until it has loaded the
// divided result. Remove and table_full beats do not use the dividers. Registers:
// the surface width at byte address 0, the surface height at 4, both reset to 1; a
// size of 0 divides as 1. The table needs no clearing pass after reset.
module touch_contact_id_remapper
	import tcir_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	tcir_evt_if.sink evt,
	tcir_res_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [SIZE_W-1:0] width_q, height_q;
	logic cfg_wr, q_full, q_pop;
	q_wr_t q_wr;
	q_rd_t q_rd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-SIZE_W){1'b0}}, height_q}
		: {{(32-SIZE_W){1'b0}}, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_W'(1);
			height_q <= SIZE_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH: width_q <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

	tcir_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.q_full(q_full),
		.q_wr(q_wr)
	);

	tcir_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.q_wr(q_wr),
		.full(q_full),
		.pop(q_pop),
		.q_rd(q_rd)
	);

	tcir_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_rd(q_rd),
		.pop(q_pop),
		.width_px(width_q),
		.height_px(height_q),
		.res(res)
	);

endmodule

FILE: sim/testbench.sv
// Testbench for the touch contact id remapper: directed table, then random event streams
`timescale 1ns / 100ps

module testbench;
	import tcir_pkg::*;

	typedef struct {
		logic [1:0] act;
		logic [31:0] cid;
		logic on_surf;
		logic [31:0] x;
		logic [31:0] y;
	} touch_ev_t;

	typedef struct {
		logic [1:0] kind;
		logic [31:0] pid;
		logic [31:0] px;
		logic [31:0] py;
		logic last;
	} beat_t;

	typedef struct {
		logic [1:0] act;
		logic [31:0] cid;
		logic on_surf;
		logic [31:0] x;
		logic [31:0] y;
		int reps;
		bit typed;
		logic [1:0] t_kind;
		logic [31:0] t_pid;
		logic [31:0] t_px;
		logic [31:0] t_py;
	} dir_row_t;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int N_DIR = 19;
	localparam int N_PHASE = 5;
	localparam int PHASE_ITEMS = 29;
	localparam int SETTLE = 200;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	bit calm;
	int faults;

	tcir_evt_if evt_ch();
	tcir_res_if res_ch();

	touch_contact_id_remapper uut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	bit slot_live [DEPTH];
	logic [31:0] slot_contact [DEPTH];
	logic [31:0] slot_pointer [DEPTH];
	logic [31:0] next_pid;
	logic [15:0] width_q;
	logic [15:0] height_q;
	beat_t fresh [$];
	beat_t due_beats [$];

	dir_row_t dir_rows [N_DIR] = '{
		'{ACT_DOWN, 32'h0, 1'b1, 32'h0, 32'h0, 1, 1'b1, KIND_ADD, 32'd1, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h7, 1'b0, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 32'h80000000, 1, 1'b1, KIND_ADD,
			32'd2, 32'h7FFFFFFF, 32'h80000000},
		'{ACT_DOWN, 32'h80000000, 1'b1, 32'h1, 32'hFFFFFFFF, 1, 1'b1, KIND_ADD,
			32'd3, 32'h00000100, 32'hFFFFFF00},
		'{ACT_MOTION, 32'h0, 1'b0, 32'd100, 32'hFFFFFF9C, 1, 1'b1, KIND_ADD,
			32'd1, 32'h00006400, 32'hFFFF9C00},
		'{ACT_MOTION, 32'd99, 1'b1, 32'h5, 32'h5, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h0, 1'b1, 32'h0, 32'h0, 1, 1'b1, KIND_ADD, 32'd4, 32'h0, 32'h0},
		'{ACT_UP, 32'h0, 1'b1, 32'h0, 32'h0, 1, 1'b1, KIND_REMOVE, 32'd4, 32'h0, 32'h0},
		'{ACT_UP, 32'h0, 1'b0, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_CANCEL, 32'h0, 1'b0, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_CANCEL, 32'h0, 1'b1, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h1000, 1'b1, 32'h00012345, 32'hFFFEDCBA, DEPTH, 1'b0, KIND_ADD,
			32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h2000, 1'b1, 32'h10, 32'h10, 1, 1'b1, KIND_FULL, 32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h1005, 1'b1, 32'hFFFFFFFF, 32'h1, 1, 1'b0, KIND_ADD,
			32'h0, 32'h0, 32'h0},
		'{ACT_MOTION, 32'h100F, 1'b0, 32'h80000000, 32'h7FFFFFFF, 1, 1'b0, KIND_ADD,
			32'h0, 32'h0, 32'h0},
		'{ACT_UP, 32'h1003, 1'b0, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h2000, 1'b1, 32'h00FFFF00, 32'hFF0000FF, 1, 1'b0, KIND_ADD,
			32'h0, 32'h0, 32'h0},
		'{ACT_CANCEL, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1'b0, KIND_ADD,
			32'h0, 32'h0, 32'h0},
		'{ACT_DOWN, 32'h0, 1'b0, 32'h0, 32'h0, 1, 1'b0, KIND_ADD, 32'h0, 32'h0, 32'h0}
	};

	function automatic logic [31:0] normalise(logic [31:0] coord, logic [15:0] size);
		longint c;
		longint d;
		longint q;
		c = longint'(signed'(coord));
		d = longint'(size);
		if (d == 0)
			d = 1;
		q = (c * 256) / d;
		if (q > 64'sh7FFFFFFF)
			q = 64'sh7FFFFFFF;
		if (q < -64'sh80000000)
			q = -64'sh80000000;
		return q[31:0];
	endfunction

	function int find_slot(logic [31:0] cid);
		for (int i = 0; i < DEPTH; i++)
			if (slot_live[i] && slot_contact[i] == cid)
				return i;
		return -1;
	endfunction

	function void remap_event(touch_ev_t e);
		int slot;
		fresh.delete();
		case (e.act)
		ACT_DOWN: begin
			if (!e.on_surf)
				return;
			slot = find_slot(e.cid);
			if (slot < 0)
				for (int i = 0; i < DEPTH; i++)
					if (!slot_live[i] && slot < 0)
						slot = i;
			if (slot < 0) begin
				fresh.insert(fresh.size(), '{KIND_FULL, 32'h0, 32'h0, 32'h0, 1'b1});
				return;
			end
			slot_live[slot] = 1'b1;
			slot_contact[slot] = e.cid;
			slot_pointer[slot] = next_pid;
			next_pid = next_pid + 32'd1;
			if (next_pid == 0)
				next_pid = 32'd1;
			fresh.insert(fresh.size(), '{KIND_ADD, slot_pointer[slot],
				normalise(e.x, width_q), normalise(e.y, height_q), 1'b1});
		end
		ACT_UP: begin
			slot = find_slot(e.cid);
			if (slot < 0)
				return;
			slot_live[slot] = 1'b0;
			fresh.insert(fresh.size(), '{KIND_REMOVE, slot_pointer[slot], 32'h0, 32'h0,
				1'b1});
		end
		ACT_MOTION: begin
			slot = find_slot(e.cid);
			if (slot < 0)
				return;
			fresh.insert(fresh.size(), '{KIND_ADD, slot_pointer[slot],
				normalise(e.x, width_q), normalise(e.y, height_q), 1'b1});
		end
		default: begin
			for (int i = 0; i < DEPTH; i++)
				if (slot_live[i])
					fresh.insert(fresh.size(), '{KIND_REMOVE, slot_pointer[i], 32'h0,
						32'h0, 1'b0});
			if (fresh.size() > 0)
				fresh[fresh.size()-1].last = 1'b1;
			for (int i = 0; i < DEPTH; i++)
				slot_live[i] = 1'b0;
		end
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
		0, 1: return $urandom;
		2, 3: return $urandom_range(0, 32'h00200000) - 32'h00100000;
		4: begin
			case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return 32'hFFFFFFFF;
			endcase
		end
		default: return $urandom & 32'h0000FFFF;
		endcase
	endfunction

	function automatic touch_ev_t pick_event();
		touch_ev_t e;
		int live_slots [$];
		int pick;
		for (int i = 0; i < DEPTH; i++)
			if (slot_live[i])
				live_slots.insert(live_slots.size(), i);
		e.act = ACT_DOWN;
		e.cid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom;
		e.on_surf = 1'b1;
		e.x = pick_coord();
		e.y = pick_coord();
		pick = $urandom_range(0, 99);
		if (pick >= 38 && pick < 78 && live_slots.size() > 0) begin
			e.act = (pick < 63) ? ACT_MOTION : ACT_UP;
			e.cid = slot_contact[live_slots[$urandom_range(0, live_slots.size() - 1)]];
			e.on_surf = 1'($urandom_range(0, 1));
		end else if (pick >= 78 && pick < 83) begin
			e.act = ACT_CANCEL;
			e.on_surf = 1'($urandom_range(0, 1));
		end else if (pick >= 83 && pick < 88) begin
			e.on_surf = 1'b0;
		end else if (pick >= 88 && pick < 95) begin
			e.act = ($urandom_range(0, 1) == 1) ? ACT_UP : ACT_MOTION;
			e.on_surf = 1'($urandom_range(0, 1));
		end else if (pick >= 95) begin
			e.act = 2'($urandom_range(0, 3));
			e.on_surf = 1'($urandom_range(0, 1));
		end
		return e;
	endfunction

	task automatic send_event(touch_ev_t e);
		evt_ch.valid <= 1'b1;
		evt_ch.action <= e.act;
		evt_ch.contact_id <= e.cid;
		evt_ch.on_target_surface <= e.on_surf;
		evt_ch.x_fixed <= e.x;
		evt_ch.y_fixed <= e.y;
		do @(posedge clk); while (!evt_ch.ready);
		remap_event(e);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic drain();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (due_beats.size() != 0);
	endtask

	task automatic write_reg(logic reg_sel, logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_WIDTH)
			width_q = value;
		else
			height_q = value;
	endtask

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			faults++;
		end
	endfunction

	always @(posedge clk) begin : watch_results
		beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_beats.size() == 0) begin
				$display("%0t: beat with nothing expected, expected none, actual kind %0d id %h",
					$time, res_ch.kind, res_ch.pointer_id);
				faults++;
			end else begin
				want = due_beats.pop_front();
				check_field("kind", {30'h0, want.kind}, {30'h0, res_ch.kind});
				check_field("pointer_id", want.pid, res_ch.pointer_id);
				check_field("pos_x", want.px, res_ch.pos_x);
				check_field("pos_y", want.py, res_ch.pos_y);
				check_field("last", {31'h0, want.last}, {31'h0, res_ch.last});
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			res_ch.ready <= 1'b1;
			if (calm) begin
				@(posedge clk);
			end else begin
				repeat ($urandom_range(1, 16)) @(posedge clk);
				if (!calm && $urandom_range(0, 2) == 0) begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		touch_ev_t e;
		logic [15:0] widths [N_PHASE];
		logic [15:0] heights [N_PHASE];
		int counted;
		widths = '{16'hFFFF, 16'h0, 16'h1, 16'h0, 16'h0};
		heights = '{16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'h0};
		widths[3] = 16'($urandom_range(2, 16'hFFFE));
		heights[3] = 16'($urandom_range(2, 2048));
		widths[4] = 16'($urandom_range(2, 2048));
		heights[4] = 16'($urandom_range(2, 16'hFFFE));
		faults = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		evt_ch.valid <= 1'b0;
		evt_ch.action <= ACT_DOWN;
		evt_ch.contact_id <= '0;
		evt_ch.on_target_surface <= 1'b0;
		evt_ch.x_fixed <= '0;
		evt_ch.y_fixed <= '0;
		for (int i = 0; i < DEPTH; i++)
			slot_live[i] = 1'b0;
		next_pid = 32'd1;
		width_q = 16'd1;
		height_q = 16'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++) begin
				e = '{dir_rows[r].act, dir_rows[r].cid + k, dir_rows[r].on_surf,
					dir_rows[r].x, dir_rows[r].y};
				maybe_pause();
				send_event(e);
				if (dir_rows[r].typed)
					due_beats.insert(due_beats.size(), '{dir_rows[r].t_kind,
						dir_rows[r].t_pid, dir_rows[r].t_px, dir_rows[r].t_py, 1'b1});
				else
					foreach (fresh[j])
						due_beats.insert(due_beats.size(), fresh[j]);
			end
		end

		for (int p = 0; p < N_PHASE; p++) begin
			drain();
			repeat (SETTLE) @(posedge clk);
			write_reg(REG_WIDTH, widths[p]);
			write_reg(REG_HEIGHT, heights[p]);
			calm = (p == N_PHASE - 1);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				e = pick_event();
				maybe_pause();
				send_event(e);
				foreach (fresh[j])
					due_beats.insert(due_beats.size(), fresh[j]);
				counted++;
				if (!calm && $urandom_range(0, 39) == 0)
					drain();
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/tcir_pkg.sv
design/tcir_if.sv
design/tcir_front.sv
design/tcir_queue.sv
design/tcir_div.sv
design/tcir_back.sv
design/touch_contact_id_remapper.sv
sim/testbench.sv
